FILE: hw/rtl/tssc_pkg.sv
// Shared types and constants of the timed stereo swap and crossfade block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tssc_pkg;

   // field and register widths
   localparam int SAMPLE_W   = 24;
   localparam int HALF_W     = 27;
   localparam int FADE_W     = 16;
   localparam int COUNT_W    = 28;
   localparam int WEIGHT_W   = 16;
   localparam int DIFF_W     = SAMPLE_W + 1;
   localparam int ACC_W      = SAMPLE_W + 2;
   localparam int BITCNT_W   = $clog2(WEIGHT_W);
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = HALF_W;

   // register values after reset
   localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(2880000);
   localparam logic [FADE_W-1:0] FADE_RESET = FADE_W'(4800);

   // register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_PERIOD = 1'b0,
      CSR_FADE        = 1'b1
   } tssc_csr_type;

   // sequencer states
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_TICK  = 7'b0000010,
      ST_PHASE = 7'b0000100,
      ST_CHECK = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_MUL   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } tssc_state_type;

   // control of one blend lane
   typedef struct packed {
      logic load;
      logic step;
      logic w_bit;
   } tssc_lane_ctl_type;

endpackage

`default_nettype wire

FILE: hw/rtl/tssc_if.sv
// Handshake channels of the timed stereo swap and crossfade block.
// Depends on tssc_pkg for the sample width.
`default_nettype none

interface tssc_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [tssc_pkg::SAMPLE_W-1:0] left_in;
   logic signed [tssc_pkg::SAMPLE_W-1:0] right_in;

   modport source (output valid, output left_in, output right_in, input ready);
   modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface tssc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [tssc_pkg::SAMPLE_W-1:0] left_out;
   logic signed [tssc_pkg::SAMPLE_W-1:0] right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/timed_stereo_swap_crossfade.sv
// Top level of the timed stereo swap and crossfade block: tick counter, sequencer,
// serial divider and two serial blend lanes. Depends on tssc_pkg, tssc_if,
// tssc_divider and tssc_blend_lane.
//
//   channel | dir | words                         | handshake
//   --------+-----+-------------------------------+-------------------
//   req     | in  | left_in, right_in (s24)       | valid/ready
//   rsp     | out | left_out, right_out (s24)     | valid/ready
//   csr     | in  | csr_index, csr_wdata (27 bit) | csr_we, no stall
//
// A crossfading word passes from accept to result through the tick, phase and
// check states of counter and phase logic, the bit-serial divider, the
// shift-add blend lanes and then the load of the output register. A word
// outside the fade skips divider and lanes. One word is in work at a time;
// a new word is accepted while the output register still waits.
// Synchronous reset clears the counter and loads the register defaults.
`default_nettype none

module timed_stereo_swap_crossfade (
   input  wire logic                              clock,
   input  wire logic                              reset,
   tssc_req_if.sink                               req,
   tssc_rsp_if.source                             rsp,
   input  wire logic                              csr_we,
   input  wire logic [tssc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tssc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tssc_pkg::*;

   tssc_state_type      state_ff, state_in;
   logic [HALF_W-1:0]   half_ff;
   logic [FADE_W-1:0]   fade_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  d_ff;
   logic                swapped_ff;
   logic [SAMPLE_W-1:0] left_ff, right_ff;
   logic [WEIGHT_W-1:0] w_ff;
   logic [BITCNT_W-1:0] bit_cnt_ff;
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_left_ff, rsp_right_ff;

   logic [COUNT_W:0]    tick;
   logic                wrap;
   logic                below;
   logic                fading;
   logic                take_in;
   logic                out_free;
   logic                div_start, div_done;
   logic [WEIGHT_W-1:0] div_quo;
   tssc_lane_ctl_type   lane_ctl;
   logic [SAMPLE_W-1:0] left_new, left_old, right_new, right_old;
   logic [SAMPLE_W-1:0] left_res, right_res;

   // counter and phase arithmetic
   assign tick   = {1'b0, count_ff} + 1'b1;
   assign wrap   = tick > {1'b0, half_ff, 1'b0};
   assign below  = count_ff < {1'b0, half_ff};
   assign fading = d_ff < {{(COUNT_W-FADE_W){1'b0}}, fade_ff};

   // handshakes
   assign take_in   = req.valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req.valid) state_in = ST_TICK;
         ST_TICK:  state_in = ST_PHASE;
         ST_PHASE: state_in = ST_CHECK;
         ST_CHECK: state_in = fading ? ST_DIV : ST_DONE;
         ST_DIV:   if (div_done) state_in = ST_MUL;
         ST_MUL:   if (bit_cnt_ff == BITCNT_W'(WEIGHT_W - 1)) state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // control registers, counter and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         half_ff      <= HALF_RESET;
         fade_ff      <= FADE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_TICK) begin
            count_ff <= wrap ? '0 : tick[COUNT_W-1:0];
         end
         if (csr_we) begin
            case (tssc_csr_type'(csr_index))
               CSR_HALF_PERIOD: half_ff <= csr_wdata[HALF_W-1:0];
               CSR_FADE:        fade_ff <= csr_wdata[FADE_W-1:0];
               default:         ;
            endcase
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // word datapath: hold samples, phase, weight and output
   always_ff @(posedge clock) begin
      if (take_in) begin
         left_ff  <= req.left_in;
         right_ff <= req.right_in;
      end
      if (state_ff == ST_PHASE) begin
         swapped_ff <= !below;
         d_ff       <= below ? count_ff : count_ff - {1'b0, half_ff};
      end
      if (state_ff == ST_DIV && div_done) begin
         w_ff       <= div_quo;
         bit_cnt_ff <= '0;
      end else if (state_ff == ST_MUL) begin
         w_ff       <= {1'b0, w_ff[WEIGHT_W-1:1]};
         bit_cnt_ff <= bit_cnt_ff + 1'b1;
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_left_ff  <= left_res;
         rsp_right_ff <= right_res;
      end
   end

   // routing: outside the fade old equals new, so the lanes pass new through
   assign left_new  = swapped_ff ? right_ff : left_ff;
   assign right_new = swapped_ff ? left_ff : right_ff;
   assign left_old  = fading ? right_new : left_new;
   assign right_old = fading ? left_new : right_new;

   assign div_start      = (state_ff == ST_CHECK) && fading;
   assign lane_ctl.load  = (state_ff == ST_CHECK);
   assign lane_ctl.step  = (state_ff == ST_MUL);
   assign lane_ctl.w_bit = w_ff[0];

   tssc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (d_ff[FADE_W-1:0]),
      .divisor  (fade_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   tssc_blend_lane u_lane_left (
      .clock   (clock),
      .ctl     (lane_ctl),
      .new_val (left_new),
      .old_val (left_old),
      .result  (left_res)
   );

   tssc_blend_lane u_lane_right (
      .clock   (clock),
      .ctl     (lane_ctl),
      .new_val (right_new),
      .old_val (right_old),
      .result  (right_res)
   );

   // output register
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.left_out  = rsp_left_ff;
   assign rsp.right_out = rsp_right_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/tssc_divider.sv
// Bit-serial restoring divider: weight = (dividend << 16) / divisor, one bit a cycle.
// Requires dividend < divisor. Depends on tssc_pkg.
`default_nettype none

module tssc_divider (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [tssc_pkg::FADE_W-1:0]    dividend,
   input  wire logic [tssc_pkg::FADE_W-1:0]    divisor,
   output logic                                done,
   output logic [tssc_pkg::WEIGHT_W-1:0]       quotient
);
   import tssc_pkg::*;

   logic [FADE_W-1:0]   rem_ff, rem_in;
   logic [FADE_W-1:0]   div_ff;
   logic [WEIGHT_W-1:0] quo_ff, quo_in;
   logic [BITCNT_W-1:0] cnt_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [FADE_W:0]     shifted;
   logic [FADE_W:0]     trial;
   logic                fits;

   // one restoring step: shift the remainder, try the subtract
   always_comb begin
      shifted = {rem_ff, 1'b0};
      trial   = shifted - {1'b0, div_ff};
      fits    = (shifted >= {1'b0, div_ff});
      rem_in  = fits ? trial[FADE_W-1:0] : shifted[FADE_W-1:0];
      quo_in  = {quo_ff[WEIGHT_W-2:0], fits};
   end

   // control: count the quotient bits, flag the last one
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == BITCNT_W'(WEIGHT_W - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == BITCNT_W'(WEIGHT_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // datapath: remainder and quotient shift registers
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend;
         div_ff <= divisor;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/tssc_blend_lane.sv
// One crossfade lane: old + round((new - old) * w / 65536), w fed LSB first.
// Shift-add multiply, one weight bit a cycle. Depends on tssc_pkg.
`default_nettype none

module tssc_blend_lane (
   input  wire logic                                clock,
   input  wire tssc_pkg::tssc_lane_ctl_type         ctl,
   input  wire logic signed [tssc_pkg::SAMPLE_W-1:0] new_val,
   input  wire logic signed [tssc_pkg::SAMPLE_W-1:0] old_val,
   output logic signed [tssc_pkg::SAMPLE_W-1:0]      result
);
   import tssc_pkg::*;

   logic [DIFF_W-1:0]   diff_ff;
   logic [SAMPLE_W-1:0] base_ff;
   logic [ACC_W-1:0]    acc_hi_ff, acc_hi_in;
   logic [WEIGHT_W-1:0] acc_lo_ff, acc_lo_in;
   logic [ACC_W-1:0]    addend;
   logic [ACC_W-1:0]    sum;
   logic [ACC_W-1:0]    total;

   // add the difference for a set weight bit, then shift right one place
   always_comb begin
      addend    = ctl.w_bit ? {diff_ff[DIFF_W-1], diff_ff} : '0;
      sum       = acc_hi_ff + addend;
      acc_hi_in = {sum[ACC_W-1], sum[ACC_W-1:1]};
      acc_lo_in = {sum[0], acc_lo_ff[WEIGHT_W-1:1]};
   end

   // hold the operands, advance the product
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         diff_ff   <= {new_val[SAMPLE_W-1], new_val} - {old_val[SAMPLE_W-1], old_val};
         base_ff   <= old_val;
         acc_hi_ff <= '0;
         acc_lo_ff <= '0;
      end else if (ctl.step) begin
         acc_hi_ff <= acc_hi_in;
         acc_lo_ff <= acc_lo_in;
      end
   end

   // round half up; a convex blend never leaves the sample range
   assign total  = {{(ACC_W-SAMPLE_W){base_ff[SAMPLE_W-1]}}, base_ff} + acc_hi_ff
                   + {{(ACC_W-1){1'b0}}, acc_lo_ff[WEIGHT_W-1]};
   assign result = total[SAMPLE_W-1:0];

endmodule

`default_nettype wire
